@@ hdl/ws_enc_pkg.sv @@
// Package for the WS2812 SPI frame encoder.
// Holds code-byte constants, register indexes and the shared types.
// Used by every file under hdl; depends on nothing else.
package ws_enc_pkg;

  // Widths fixed by the field definitions.
  localparam int unsigned COLOR_W    = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned BCNT_W     = 4;
  localparam int unsigned PCOUNT_W   = 11;
  localparam int unsigned RBYTES_W   = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned NUM_LANES  = 3;

  // SPI code bytes: one code byte per pixel data bit.
  localparam logic [7:0] CODE_ONE  = 8'h78;
  localparam logic [7:0] CODE_ZERO = 8'h60;

  // A full word carries eight code bytes.
  localparam logic [BCNT_W-1:0]   BYTES_PER_WORD   = 4'd8;
  localparam logic [RBYTES_W-1:0] BYTES_PER_WORD_R = 8'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTES  = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [PCOUNT_W-1:0] PIXEL_COUNT_RST = 11'd8;
  localparam logic [RBYTES_W-1:0] TAIL_BYTES_RST  = 8'd80;

  // Which word of the current pixel goes out next.
  typedef enum logic [3:0] {
    SEL_GREEN = 4'b0001,
    SEL_RED   = 4'b0010,
    SEL_BLUE  = 4'b0100,
    SEL_ZERO  = 4'b1000
  } sel_t;

  // Frame control captured with each pixel item.
  typedef struct packed {
    logic                last;
    logic [RBYTES_W-1:0] left;
  } job_t;

  typedef logic [NUM_LANES-1:0][WORD_W-1:0] lane_words_t;

endpackage

@@ hdl/ws_enc_if.sv @@
// Handshake channels of the WS2812 SPI frame encoder: pixel in, word out, config.
// Depends on ws_enc_pkg for the field widths.
interface ws_enc_pix_if;
  logic                                valid;
  logic                                ready;
  logic [ws_enc_pkg::COLOR_W-1:0]      green;
  logic [ws_enc_pkg::COLOR_W-1:0]      red;
  logic [ws_enc_pkg::COLOR_W-1:0]      blue;

  modport source (output valid, green, red, blue, input ready);
  modport sink   (input valid, green, red, blue, output ready);
endinterface

interface ws_enc_word_if;
  logic                                valid;
  logic                                ready;
  logic [ws_enc_pkg::WORD_W-1:0]       code_word;
  logic [ws_enc_pkg::BCNT_W-1:0]       byte_count;
  logic                                frame_end;

  modport source (output valid, code_word, byte_count, frame_end, input ready);
  modport sink   (input valid, code_word, byte_count, frame_end, output ready);
endinterface

interface ws_enc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ws_enc_pkg::CFG_IDX_W-1:0]    index;
  logic [ws_enc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/ws_enc_lane.sv @@
// One encoder lane: expands a colour byte into eight SPI code bytes.
// Depends on ws_enc_pkg for the code bytes and widths.
module ws_enc_lane (
  input  logic                              clk,
  input  logic                              load,
  input  logic [ws_enc_pkg::COLOR_W-1:0]    color,
  output logic [ws_enc_pkg::WORD_W-1:0]     word
);

  logic [ws_enc_pkg::WORD_W-1:0] word_r;
  logic [ws_enc_pkg::WORD_W-1:0] word_nxt;

  // Each data bit maps to one code byte, MSB first in the top byte.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      word_nxt[ws_enc_pkg::WORD_W-1-8*k -: 8] =
        color[7-k] ? ws_enc_pkg::CODE_ONE : ws_enc_pkg::CODE_ZERO;
    end
  end

  // The word is held until the merge stage has sent it.
  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_nxt;
    end
  end

  assign word = word_r;

endmodule

@@ hdl/ws_enc_merge.sv @@
// Merge stage: sends the three lane words of a pixel, then the frame's zero words.
// Depends on ws_enc_pkg for sel_t, job_t and the word constants.
module ws_enc_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  ws_enc_pkg::job_t                  job_in,
  input  ws_enc_pkg::lane_words_t           lane_words,
  output logic                              job_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ws_enc_pkg::WORD_W-1:0]     out_code_word,
  output logic [ws_enc_pkg::BCNT_W-1:0]     out_byte_count,
  output logic                              out_frame_end
);

  logic                              job_vld_r;
  ws_enc_pkg::sel_t                  sel_r;
  ws_enc_pkg::sel_t                  sel_nxt;
  logic                              last_r;
  logic [ws_enc_pkg::RBYTES_W-1:0]   left_r;
  logic [ws_enc_pkg::RBYTES_W-1:0]   left_nxt;
  logic                              out_vld_r;
  logic [ws_enc_pkg::WORD_W-1:0]     out_word_r;
  logic [ws_enc_pkg::WORD_W-1:0]     word_nxt;
  logic [ws_enc_pkg::BCNT_W-1:0]     out_cnt_r;
  logic [ws_enc_pkg::BCNT_W-1:0]     cnt_nxt;
  logic                              out_end_r;
  logic                              end_nxt;
  logic                              final_word;
  logic                              adv;
  logic [ws_enc_pkg::RBYTES_W-1:0]   take;

  // A word moves to the output register when that register is free or drains.
  assign adv      = job_vld_r && (!out_vld_r || out_ready);
  assign job_free = !job_vld_r || (adv && final_word);

  // Zero words carry up to eight bytes.
  assign take = (left_r > ws_enc_pkg::BYTES_PER_WORD_R) ?
                ws_enc_pkg::BYTES_PER_WORD_R : left_r;

  // Pick the next word and decide whether it ends this pixel's work.
  always_comb begin
    sel_nxt    = sel_r;
    left_nxt   = left_r;
    word_nxt   = '0;
    cnt_nxt    = ws_enc_pkg::BYTES_PER_WORD;
    end_nxt    = 1'b0;
    final_word = 1'b0;
    case (sel_r)
      ws_enc_pkg::SEL_GREEN: begin
        word_nxt = lane_words[0];
        sel_nxt  = ws_enc_pkg::SEL_RED;
      end
      ws_enc_pkg::SEL_RED: begin
        word_nxt = lane_words[1];
        sel_nxt  = ws_enc_pkg::SEL_BLUE;
      end
      ws_enc_pkg::SEL_BLUE: begin
        word_nxt   = lane_words[2];
        end_nxt    = last_r && (left_r == '0);
        final_word = !last_r || (left_r == '0);
        sel_nxt    = ws_enc_pkg::SEL_ZERO;
      end
      ws_enc_pkg::SEL_ZERO: begin
        left_nxt   = left_r - take;
        cnt_nxt    = take[ws_enc_pkg::BCNT_W-1:0];
        end_nxt    = (left_nxt == '0);
        final_word = end_nxt;
      end
      default: begin
        sel_nxt = ws_enc_pkg::SEL_GREEN;
      end
    endcase
  end

  // Pixel job register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
      sel_r     <= ws_enc_pkg::SEL_GREEN;
      last_r    <= 1'b0;
      left_r    <= '0;
    end else if (load) begin
      job_vld_r <= 1'b1;
      sel_r     <= ws_enc_pkg::SEL_GREEN;
      last_r    <= job_in.last;
      left_r    <= job_in.left;
    end else if (adv) begin
      if (final_word) begin
        job_vld_r <= 1'b0;
      end
      sel_r  <= sel_nxt;
      left_r <= left_nxt;
    end
  end

  // Output register, loaded whenever the sequencer advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= word_nxt;
      out_cnt_r  <= cnt_nxt;
      out_end_r  <= end_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_code_word  = out_word_r;
  assign out_byte_count = out_cnt_r;
  assign out_frame_end  = out_end_r;

  // Zero words only exist for the last pixel of a frame.
  a_zero_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (job_vld_r && sel_r == ws_enc_pkg::SEL_ZERO) |-> (last_r && left_r != '0))
    else $error("zero phase entered without pending reset bytes");

  // A short word is always an all-zero frame end word.
  a_short_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_cnt_r != ws_enc_pkg::BYTES_PER_WORD) |->
      (out_end_r && out_word_r == '0))
    else $error("short word that is not a final zero word");

  // Byte count stays within one to eight.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_cnt_r != '0 && out_cnt_r <= ws_enc_pkg::BYTES_PER_WORD))
    else $error("byte count out of range");

  // A new pixel is only taken once the previous one has been fully issued.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load && job_vld_r) |-> (adv && final_word))
    else $error("pixel job overwritten before its last word");

endmodule

@@ hdl/ws2812_spi_frame_encoder_unit.sv @@
// WS2812 SPI frame encoder, top level: config registers, pixel position, lanes.
// Depends on ws_enc_pkg, ws_enc_if, ws_enc_lane and ws_enc_merge.
//
// Each accepted pixel (green, red, blue) produces three 64-bit words, one per
// colour, each holding eight SPI code bytes (0x78 for a one bit, 0x60 for a
// zero bit, MSB first, first-sent byte in bits 63:56). After the last pixel of
// a frame, the configured number of trailing zero bytes follow in words of up
// to eight bytes and the final word carries frame_end; with no trailing bytes
// the blue word carries it.
// The output port moves one word per cycle while the receiver is ready. The next
// pixel is taken in the cycle the current one issues its final word, so pixels
// stream back to back. A pixel count of zero acts as one and a count above
// MAX_PIXELS acts as MAX_PIXELS. Config writes are always taken and must only
// be made while no pixel is in flight.
module ws2812_spi_frame_encoder_unit #(
  parameter int unsigned MAX_PIXELS = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  ws_enc_pix_if.sink    in_pix,
  ws_enc_word_if.source out_word,
  ws_enc_cfg_if.sink    cfg_wr
);

  localparam int unsigned POS_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned LIM_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CMP_W =
    ((LIM_W > ws_enc_pkg::PCOUNT_W) ? LIM_W : ws_enc_pkg::PCOUNT_W) + 1;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_PIXELS);

  logic [ws_enc_pkg::PCOUNT_W-1:0] pixel_count_r;
  logic [ws_enc_pkg::RBYTES_W-1:0] tail_bytes_r;
  logic [POS_W-1:0]                pos_r;
  logic [POS_W-1:0]                pos_nxt;
  logic [CMP_W-1:0]                pc_ext;
  logic [CMP_W-1:0]                limit;
  logic [CMP_W-1:0]                pos_inc;
  logic                            last_pixel;
  logic                            job_free;
  logic                            load;
  ws_enc_pkg::job_t                job_in;
  ws_enc_pkg::lane_words_t         lane_words;
  logic [ws_enc_pkg::COLOR_W-1:0]  colors [ws_enc_pkg::NUM_LANES];

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_count_r <= ws_enc_pkg::PIXEL_COUNT_RST;
      tail_bytes_r  <= ws_enc_pkg::TAIL_BYTES_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        ws_enc_pkg::REG_PIXEL_COUNT: pixel_count_r <= cfg_wr.data;
        ws_enc_pkg::REG_TAIL_BYTES:
          tail_bytes_r <= cfg_wr.data[ws_enc_pkg::RBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame length and last-pixel test.
  assign pc_ext     = CMP_W'(pixel_count_r);
  assign limit      = (pc_ext == '0) ? CMP_W'(1) :
                      ((pc_ext > MAX_CMP) ? MAX_CMP : pc_ext);
  assign pos_inc    = CMP_W'(pos_r) + CMP_W'(1);
  assign last_pixel = (pos_inc >= limit);
  assign pos_nxt    = last_pixel ? '0 : pos_inc[POS_W-1:0];

  // Input handshake.
  assign in_pix.ready = job_free;
  assign load         = in_pix.valid && job_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (load) begin
      pos_r <= pos_nxt;
    end
  end

  assign job_in.last = last_pixel;
  assign job_in.left = last_pixel ? tail_bytes_r : '0;

  // One encoder lane per colour, in send order.
  assign colors[0] = in_pix.green;
  assign colors[1] = in_pix.red;
  assign colors[2] = in_pix.blue;

  for (genvar g = 0; g < ws_enc_pkg::NUM_LANES; g++) begin : g_lane
    ws_enc_lane u_lane (
      .clk   (clk),
      .load  (load),
      .color (colors[g]),
      .word  (lane_words[g])
    );
  end

  // Merge stage sequences lane words and trailing zero words.
  ws_enc_merge u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .job_in         (job_in),
    .lane_words     (lane_words),
    .job_free       (job_free),
    .out_valid      (out_word.valid),
    .out_ready      (out_word.ready),
    .out_code_word  (out_word.code_word),
    .out_byte_count (out_word.byte_count),
    .out_frame_end  (out_word.frame_end)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ws2812_spi_frame_encoder_unit: pixels in, code words out.
// Depends on ws_enc_pkg and the channel interfaces in ws_enc_if; predicts every word.
module testbench;

  localparam int unsigned MAX_FRAME_PIXELS = 1024;
  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned LONG_HOLD        = 150;
  localparam logic [ws_enc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [ws_enc_pkg::COLOR_W-1:0] green;
    logic [ws_enc_pkg::COLOR_W-1:0] red;
    logic [ws_enc_pkg::COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct {
    logic [ws_enc_pkg::WORD_W-1:0] code_word;
    logic [ws_enc_pkg::BCNT_W-1:0] byte_count;
    logic                          frame_end;
  } code_word_t;

  logic clk = 1'b0;
  logic rst_n;

  ws_enc_pix_if  pix_ch ();
  ws_enc_word_if word_ch ();
  ws_enc_cfg_if  cfg_ch ();

  ws2812_spi_frame_encoder_unit #(
    .MAX_PIXELS(MAX_FRAME_PIXELS)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch),
    .out_word(word_ch),
    .cfg_wr  (cfg_ch)
  );

  // Pixels waiting to go out, and the words the encoder still owes.
  pixel_t      pixels_to_send[$];
  code_word_t  words_due[$];
  int unsigned pixels_queued = 0;
  int unsigned pixels_taken  = 0;
  int unsigned errors        = 0;
  int unsigned cycles        = 0;

  // Handshakes seen at the last rising edge.
  logic pix_took  = 1'b0;
  logic word_took = 1'b0;
  logic cfg_took  = 1'b0;

  // Receiver hold-off request and its state.
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  // Predictor state: register copies and the position within the frame.
  logic [ws_enc_pkg::PCOUNT_W-1:0] frame_pixels = ws_enc_pkg::PIXEL_COUNT_RST;
  logic [ws_enc_pkg::RBYTES_W-1:0] tail_bytes   = ws_enc_pkg::TAIL_BYTES_RST;
  int unsigned                     frame_pos    = 0;

  always #2 clk = ~clk;

  // One code byte per color bit, most significant bit first in the top byte.
  function automatic logic [ws_enc_pkg::WORD_W-1:0] expand_color(
    logic [ws_enc_pkg::COLOR_W-1:0] color);
    logic [ws_enc_pkg::WORD_W-1:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      w[ws_enc_pkg::WORD_W-1-8*k -: 8] =
        color[7-k] ? ws_enc_pkg::CODE_ONE : ws_enc_pkg::CODE_ZERO;
    end
    return w;
  endfunction

  // Work out the words one pixel produces and advance the frame position.
  function automatic void encode_pixel(pixel_t p);
    int unsigned                     span;
    logic                            last;
    logic [ws_enc_pkg::RBYTES_W-1:0] left;
    logic [ws_enc_pkg::BCNT_W-1:0]   take;
    logic [ws_enc_pkg::COLOR_W-1:0]  colors [3];
    code_word_t                      w;
    span = (frame_pixels == 0) ? 1 : 32'(frame_pixels);
    if (span > MAX_FRAME_PIXELS) span = MAX_FRAME_PIXELS;
    last = (frame_pos + 1 >= span);
    colors = '{p.green, p.red, p.blue};
    for (int c = 0; c < 3; c++) begin
      w.code_word  = expand_color(colors[c]);
      w.byte_count = ws_enc_pkg::BYTES_PER_WORD;
      w.frame_end  = last && (tail_bytes == 0) && (c == 2);
      words_due.push_back(w);
    end
    if (last) begin
      // Trailing zero bytes, eight to a word, the final word ends the frame.
      left = tail_bytes;
      while (left > 0) begin
        take = (left > ws_enc_pkg::BYTES_PER_WORD_R) ? ws_enc_pkg::BYTES_PER_WORD :
               left[ws_enc_pkg::BCNT_W-1:0];
        left = left - ws_enc_pkg::RBYTES_W'(take);
        w.code_word  = '0;
        w.byte_count = take;
        w.frame_end  = (left == 0);
        words_due.push_back(w);
      end
      frame_pos = 0;
    end else begin
      frame_pos++;
    end
  endfunction

  function automatic void apply_reg(logic [ws_enc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [ws_enc_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      ws_enc_pkg::REG_PIXEL_COUNT: frame_pixels = val[ws_enc_pkg::PCOUNT_W-1:0];
      ws_enc_pkg::REG_TAIL_BYTES:  tail_bytes = val[ws_enc_pkg::RBYTES_W-1:0];
      default: ;
    endcase
  endfunction

  // Wait before the next item: usually a random draw, with calm stretches of none.
  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  task automatic flag_mismatch(input string what,
                               input logic [ws_enc_pkg::WORD_W-1:0] got,
                               input logic [ws_enc_pkg::WORD_W-1:0] want);
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // Sender: presents queued pixels and holds each until it is taken.
  int unsigned send_wait = 0;
  int unsigned send_calm = 0;
  always @(negedge clk) begin
    pixel_t p;
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
    end else if (pix_ch.valid && !pix_took) begin
      // Item still on offer.
    end else if (send_wait > 0) begin
      send_wait--;
      pix_ch.valid <= 1'b0;
    end else if (pixels_to_send.size() > 0) begin
      p = pixels_to_send.pop_front();
      pix_ch.valid <= 1'b1;
      pix_ch.green <= p.green;
      pix_ch.red   <= p.red;
      pix_ch.blue  <= p.blue;
      send_wait = draw_wait(send_calm);
    end else begin
      pix_ch.valid <= 1'b0;
    end
  end

  // Receiver: stalls at random after each word, and once for a long stretch.
  int unsigned recv_wait = 0;
  int unsigned recv_calm = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      word_ch.ready <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        word_ch.ready <= 1'b0;
      end else if (word_took) begin
        recv_wait = draw_wait(recv_calm);
        word_ch.ready <= (recv_wait == 0);
      end else if (recv_wait > 0) begin
        recv_wait--;
        word_ch.ready <= (recv_wait == 0);
      end else begin
        word_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: tracks handshakes, updates the predictor and checks each word.
  always @(posedge clk) begin
    code_word_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    pix_took  <= rst_n && pix_ch.valid && pix_ch.ready;
    word_took <= rst_n && word_ch.valid && word_ch.ready;
    cfg_took  <= rst_n && cfg_ch.valid && cfg_ch.ready;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
      if (pix_ch.valid && pix_ch.ready) begin
        encode_pixel('{pix_ch.green, pix_ch.red, pix_ch.blue});
        pixels_taken++;
      end
      if (word_ch.valid === 1'b1 && word_ch.ready) begin
        if (words_due.size() == 0) begin
          flag_mismatch("word with nothing expected", word_ch.code_word, '0);
        end else begin
          want = words_due.pop_front();
          if (word_ch.code_word !== want.code_word)
            flag_mismatch("code_word", word_ch.code_word, want.code_word);
          if (word_ch.byte_count !== want.byte_count)
            flag_mismatch("byte_count", ws_enc_pkg::WORD_W'(word_ch.byte_count),
                          ws_enc_pkg::WORD_W'(want.byte_count));
          if (word_ch.frame_end !== want.frame_end)
            flag_mismatch("frame_end", ws_enc_pkg::WORD_W'(word_ch.frame_end),
                          ws_enc_pkg::WORD_W'(want.frame_end));
        end
      end
    end
  end

  function automatic void queue_pixel(logic [ws_enc_pkg::COLOR_W-1:0] g,
                                      logic [ws_enc_pkg::COLOR_W-1:0] r,
                                      logic [ws_enc_pkg::COLOR_W-1:0] b);
    pixels_to_send.push_back('{g, r, b});
    pixels_queued++;
  endfunction

  // Mostly uniform colors, now and then all zeros or all ones.
  function automatic logic [ws_enc_pkg::COLOR_W-1:0] rand_color();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return ws_enc_pkg::COLOR_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(input logic [ws_enc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ws_enc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stimulus pauses until every pixel is taken and every word has arrived.
  task automatic wait_idle();
    while (pixels_taken != pixels_queued || words_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Stimulus: directed cases, then random phases with fresh register settings.
  initial begin
    logic [ws_enc_pkg::CFG_DATA_W-1:0] count_val;
    logic [ws_enc_pkg::CFG_DATA_W-1:0] tail_val;
    rst_n         = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: a full eight-pixel frame with 80 trailing bytes, then two more.
    queue_pixel(8'h00, 8'h00, 8'h00);
    queue_pixel(8'hFF, 8'hFF, 8'hFF);
    queue_pixel(8'hAA, 8'h55, 8'h0F);
    queue_pixel(8'h55, 8'hAA, 8'hF0);
    queue_pixel(8'h80, 8'h01, 8'h80);
    queue_pixel(8'h01, 8'h80, 8'h01);
    queue_pixel(8'hFF, 8'h00, 8'hFF);
    queue_pixel(8'h00, 8'hFF, 8'h00);
    queue_pixel(8'h12, 8'h34, 8'h56);
    queue_pixel(8'hC3, 8'h3C, 8'h7E);
    wait_idle();

    // Count lowered below the current position, and no trailing bytes.
    write_reg(ws_enc_pkg::REG_PIXEL_COUNT, 11'd1);
    write_reg(ws_enc_pkg::REG_TAIL_BYTES, 11'd0);
    queue_pixel(8'hFF, 8'h00, 8'h81);
    queue_pixel(8'h7E, 8'hFF, 8'h00);
    queue_pixel(8'h00, 8'h00, 8'hFF);
    wait_idle();

    // Zero pixel count acts as one; trailing bytes leave a partial word.
    write_reg(ws_enc_pkg::REG_PIXEL_COUNT, 11'd0);
    write_reg(ws_enc_pkg::REG_TAIL_BYTES, 11'd13);
    queue_pixel(8'h5A, 8'hA5, 8'h3C);
    queue_pixel(8'hFF, 8'hFF, 8'h00);
    wait_idle();

    // Count above the maximum saturates; upper data bits of the byte count drop.
    write_reg(ws_enc_pkg::REG_PIXEL_COUNT, 11'h7FF);
    write_reg(ws_enc_pkg::REG_TAIL_BYTES, 11'h7FF);
    write_reg(REG_UNUSED, 11'h555);
    queue_pixel(8'h01, 8'h02, 8'h04);
    queue_pixel(8'h08, 8'h10, 8'h20);
    queue_pixel(8'h40, 8'h80, 8'hFE);
    wait_idle();

    // Lowered again mid-frame: the next pixel ends it with 255 trailing bytes.
    write_reg(REG_UNUSED, 11'h2AA);
    write_reg(ws_enc_pkg::REG_PIXEL_COUNT, 11'd4);
    queue_pixel(8'hEF, 8'hBE, 8'hAD);
    queue_pixel(8'hDE, 8'hC0, 8'h11);
    wait_idle();

    // Random phases.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: count_val = ws_enc_pkg::CFG_DATA_W'(MAX_FRAME_PIXELS);
        4: count_val = '1;
        8: count_val = '0;
        default: count_val = ws_enc_pkg::CFG_DATA_W'($urandom_range(1, 9));
      endcase
      case (ph % 4)
        0: tail_val = 11'd0;
        1: tail_val = 11'd8;
        2: tail_val = 11'd255;
        default: tail_val = ws_enc_pkg::CFG_DATA_W'($urandom_range(1, 254));
      endcase
      write_reg(ws_enc_pkg::REG_PIXEL_COUNT, count_val);
      write_reg(ws_enc_pkg::REG_TAIL_BYTES, tail_val);
      if (ph == 1) hold_req = 1'b1;
      for (int i = 0; i < 32; i++) begin
        if (ph == 6 && i == 16) wait_idle();
        queue_pixel(rand_color(), rand_color(), rand_color());
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ws_enc_pkg.sv
hdl/ws_enc_if.sv
hdl/ws_enc_lane.sv
hdl/ws_enc_merge.sv
hdl/ws2812_spi_frame_encoder_unit.sv
verif/testbench.sv
